// ===== rtl/ddfd_pkg.sv =====
package ddfd_pkg;

  localparam int FRAME_BYTES_DEF = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int HEIGHT_W   = 14;
  localparam int EVENT_W    = 3;
  localparam int TIME_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BOOT_WAIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_POLL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_POLL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_TIMEOUT  = 2'd3;

  localparam logic [CFG_DATA_W-1:0] BOOT_WAIT_RST   = 20'd10000;
  localparam logic [CFG_DATA_W-1:0] IDLE_POLL_RST   = 20'd3000;
  localparam logic [CFG_DATA_W-1:0] ACTIVE_POLL_RST = 20'd330;
  localparam logic [CFG_DATA_W-1:0] ACT_TIMEOUT_RST = 20'd2000;

  localparam logic [EVENT_W-1:0] EV_HEIGHT   = 3'd0;
  localparam logic [EVENT_W-1:0] EV_DISPLAY  = 3'd1;
  localparam logic [EVENT_W-1:0] EV_WAKE     = 3'd2;
  localparam logic [EVENT_W-1:0] EV_BAD_END  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_OVERSIZE = 3'd4;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [7:0] SOF_A_BYTE  = 8'h9B;
  localparam logic [7:0] SOF_B_BYTE  = 8'h98;
  localparam logic [7:0] EOF_BYTE    = 8'h9D;
  localparam logic [7:0] TYPE_HEIGHT = 8'h12;
  localparam logic [7:0] HEIGHT_LEN  = 8'd7;

  localparam logic [3:0] SEG_MINUS = 4'd10;
  localparam logic [3:0] SEG_BLANK = 4'd14;
  localparam logic [3:0] SEG_BAD   = 4'd15;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [EVENT_W-1:0]  event_res;
    logic [HEIGHT_W-1:0] height_tenths;
  } out_item_t;

  typedef struct packed {
    logic      vld;
    out_item_t item;
  } res_t;

  typedef struct packed {
    logic changed;
    logic prev_nonzero;
  } hchg_t;

  function automatic logic [3:0] seg_decode(input logic [7:0] b);
    logic [3:0] code;
    begin
      case (b[6:0])
        7'h00:   code = SEG_BLANK;
        7'h3F:   code = 4'd0;
        7'h06:   code = 4'd1;
        7'h5B:   code = 4'd2;
        7'h4F:   code = 4'd3;
        7'h66:   code = 4'd4;
        7'h6D:   code = 4'd5;
        7'h7D:   code = 4'd6;
        7'h07:   code = 4'd7;
        7'h7F:   code = 4'd8;
        7'h6F:   code = 4'd9;
        7'h40:   code = SEG_MINUS;
        default: code = SEG_BAD;
      endcase
      return code;
    end
  endfunction

endpackage

// ===== rtl/ddfd_parser.sv =====
module ddfd_parser #(
  parameter int FRAME_BYTES = ddfd_pkg::FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  ddfd_pkg::in_item_t item,
  output ddfd_pkg::res_t     res,
  output ddfd_pkg::hchg_t    hchg
);
  import ddfd_pkg::*;

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int TW = 9;

  logic [CW-1:0]       cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]          len_r, len_nxt, type_r, type_nxt, len_eff;
  logic [2:0][7:0]     dig_r, dig_nxt;
  logic [HEIGHT_W-1:0] cur_r, cur_nxt, rep_r, rep_nxt;
  logic [TW-1:0]       total;
  logic [3:0]          a_code, b_code, c_code, a_val;
  logic                all_blank, digits_ok;
  logic [HEIGHT_W-1:0] hsum, hval;

  always_comb begin
    a_code    = seg_decode(dig_r[0]);
    b_code    = seg_decode(dig_r[1]);
    c_code    = seg_decode(dig_r[2]);
    all_blank = (a_code == SEG_BLANK) && (b_code == SEG_BLANK) && (c_code == SEG_BLANK);
    a_val     = (a_code == SEG_BLANK) ? 4'd0 : a_code;
    digits_ok = !all_blank && (a_val <= SEG_MINUS) && (b_code <= SEG_MINUS) &&
                (c_code <= SEG_MINUS) && (b_code != SEG_MINUS) &&
                !((a_val == 4'd0) && (b_code == 4'd0) && (c_code == 4'd0));
    hsum      = HEIGHT_W'(a_val) * HEIGHT_W'(100) + HEIGHT_W'(b_code) * HEIGHT_W'(10) +
                HEIGHT_W'(c_code);
    hval      = dig_r[1][7] ? hsum : hsum * HEIGHT_W'(10);
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    type_nxt = type_r;
    dig_nxt  = dig_r;
    cur_nxt  = cur_r;
    rep_nxt  = rep_r;
    res      = '0;
    hchg     = '0;
    cnt_inc  = cnt_r + 1'b1;
    len_eff  = (cnt_r == CW'(1)) ? item.rx_byte : len_r;
    total    = TW'(len_eff) + TW'(2);
    if (go && (item.kind == KIND_BYTE)) begin
      if (cnt_r == '0) begin
        if ((item.rx_byte == SOF_A_BYTE) || (item.rx_byte == SOF_B_BYTE)) begin
          cnt_nxt = CW'(1);
        end
      end else begin
        if (cnt_r == CW'(1)) len_nxt = item.rx_byte;
        if (cnt_r == CW'(2)) type_nxt = item.rx_byte;
        if (cnt_r == CW'(3)) dig_nxt[0] = item.rx_byte;
        if (cnt_r == CW'(4)) dig_nxt[1] = item.rx_byte;
        if (cnt_r == CW'(5)) dig_nxt[2] = item.rx_byte;
        if (total > TW'(FRAME_BYTES)) begin
          cnt_nxt                = '0;
          res.vld                = 1'b1;
          res.item.event_res     = EV_OVERSIZE;
        end else if (TW'(cnt_inc) >= total) begin
          cnt_nxt = '0;
          if (item.rx_byte != EOF_BYTE) begin
            res.vld            = 1'b1;
            res.item.event_res = EV_BAD_END;
          end else if ((len_eff == HEIGHT_LEN) && (type_r == TYPE_HEIGHT) && digits_ok) begin
            hchg.changed      = (hval != cur_r);
            hchg.prev_nonzero = (cur_r != '0);
            cur_nxt           = hval;
            if (hval != rep_r) begin
              rep_nxt                = hval;
              res.vld                = 1'b1;
              res.item.event_res     = EV_HEIGHT;
              res.item.height_tenths = hval;
            end
          end
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cur_r <= '0;
      rep_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      cur_r <= cur_nxt;
      rep_r <= rep_nxt;
    end
    len_r  <= len_nxt;
    type_r <= type_nxt;
    dig_r  <= dig_nxt;
  end

endmodule

// ===== rtl/ddfd_poll.sv =====
module ddfd_poll (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic                              tick,
  input  ddfd_pkg::hchg_t                   hchg,
  input  logic                              cfg_we,
  input  logic [ddfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ddfd_pkg::res_t                    res
);
  import ddfd_pkg::*;

  typedef enum logic [1:0] {MODE_BOOT, MODE_IDLE, MODE_ACTIVE} mode_t;

  mode_t                 mode_r, mode_nxt;
  logic [TIME_W-1:0]     time_r, time_nxt, poll_r, poll_nxt, chg_r, chg_nxt;
  logic [CFG_DATA_W-1:0] boot_r, idle_r, active_r, tout_r;
  logic [TIME_W-1:0]     since_poll, since_chg;

  always_comb begin
    mode_nxt   = mode_r;
    time_nxt   = time_r;
    poll_nxt   = poll_r;
    chg_nxt    = chg_r;
    res        = '0;
    since_poll = (time_r + 1'b1) - poll_r;
    since_chg  = (time_r + 1'b1) - chg_r;
    if (go && tick) begin
      time_nxt = time_r + 1'b1;
      case (mode_r)
        MODE_BOOT: begin
          if (time_nxt >= TIME_W'(boot_r)) begin
            poll_nxt           = time_nxt;
            mode_nxt           = MODE_IDLE;
            res.vld            = 1'b1;
            res.item.event_res = EV_DISPLAY;
          end
        end
        MODE_ACTIVE: begin
          if (since_poll >= TIME_W'(active_r)) begin
            poll_nxt           = time_nxt;
            res.vld            = 1'b1;
            res.item.event_res = EV_WAKE;
          end
          if (since_chg >= TIME_W'(tout_r)) mode_nxt = MODE_IDLE;
        end
        default: begin
          if (since_poll >= TIME_W'(idle_r)) begin
            poll_nxt           = time_nxt;
            res.vld            = 1'b1;
            res.item.event_res = EV_WAKE;
          end
        end
      endcase
    end else if (go && hchg.changed) begin
      chg_nxt = time_r;
      if (hchg.prev_nonzero && (mode_r == MODE_IDLE)) mode_nxt = MODE_ACTIVE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BOOT;
      time_r   <= '0;
      poll_r   <= '0;
      chg_r    <= '0;
      boot_r   <= BOOT_WAIT_RST;
      idle_r   <= IDLE_POLL_RST;
      active_r <= ACTIVE_POLL_RST;
      tout_r   <= ACT_TIMEOUT_RST;
    end else begin
      mode_r <= mode_nxt;
      time_r <= time_nxt;
      poll_r <= poll_nxt;
      chg_r  <= chg_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_BOOT_WAIT:   boot_r   <= cfg_wdata;
          REG_IDLE_POLL:   idle_r   <= cfg_wdata;
          REG_ACTIVE_POLL: active_r <= cfg_wdata;
          REG_ACT_TIMEOUT: tout_r   <= cfg_wdata;
          default:         tout_r   <= tout_r;
        endcase
      end
    end
  end

endmodule

// ===== rtl/desk_display_frame_decoder_unit.sv =====
// Channel   Direction  Handshake        Beat
// in_       input      in_valid/stall   in_item: kind, rx_byte
// out_      output     out_valid/stall  out_item: event_res, height_tenths
// cfg_      input      cfg_we           cfg_index, cfg_wdata
//
// Each beat is captured in an input register and decoded, and its result, if
// any, lands in the output register; one beat per cycle is sustained while the
// output is not stalled. Reset is synchronous and active low; it returns
// the frame parser, the millisecond timer and the registers to their defaults.
// A stalled result holds the output register; the input register then fills
// and in_stall rises until the result is taken.
module desk_display_frame_decoder_unit #(
  parameter int FRAME_BYTES = ddfd_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ddfd_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ddfd_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [ddfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ddfd_pkg::*;

  in_item_t  in_r;
  logic      in_vld_r, in_vld_nxt;
  out_item_t out_r, out_nxt;
  logic      out_vld_r, out_vld_nxt;
  logic      advance, accept;
  res_t      p_res, t_res;
  hchg_t     hchg;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign accept   = in_valid && !in_stall;

  ddfd_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parser (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (advance),
    .item (in_r),
    .res  (p_res),
    .hchg (hchg)
  );

  ddfd_poll u_poll (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (advance),
    .tick     (in_r.kind == KIND_TICK),
    .hchg     (hchg),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .res      (t_res)
  );

  always_comb begin
    in_vld_nxt  = in_vld_r;
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    if (out_vld_r && !out_stall) out_vld_nxt = 1'b0;
    if (advance && p_res.vld) begin
      out_vld_nxt = 1'b1;
      out_nxt     = p_res.item;
    end else if (advance && t_res.vld) begin
      out_vld_nxt = 1'b1;
      out_nxt     = t_res.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if (accept) in_r <= in_item;
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(p_res.vld && t_res.vld))
    else $error("parser and timer both produced a result");

  a_height_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.event_res == EV_HEIGHT)) |-> (out_item.height_tenths != '0))
    else $error("height report with zero height");

  a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.event_res != EV_HEIGHT)) |-> (out_item.height_tenths == '0))
    else $error("non-height event carries a height");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_vld_r && out_stall) |=> (in_vld_r && $stable(in_r)))
    else $error("input register lost a beat while the output stalled");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ddfd_pkg::*;

  localparam int FRAME_MAX   = FRAME_BYTES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 4;

  // Digit codes used when building frames: 0..9 are numerals.
  localparam int DIG_MINUS = 10;
  localparam int DIG_BLANK = 11;
  localparam int DIG_ODD   = 12;

  typedef enum logic [1:0] {MODE_BOOT, MODE_IDLE, MODE_ACTIVE} poll_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always #6 clk = ~clk;

  desk_display_frame_decoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the decoder state and timing registers.
  logic [CFG_DATA_W-1:0] boot_wait;
  logic [CFG_DATA_W-1:0] idle_poll;
  logic [CFG_DATA_W-1:0] active_poll;
  logic [CFG_DATA_W-1:0] act_timeout;
  int frame_fill;
  logic [7:0] frame_buf [0:FRAME_MAX-1];
  poll_mode_t mode;
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] last_poll;
  logic [TIME_W-1:0] last_change;
  logic [HEIGHT_W-1:0] cur_height;
  logic [HEIGHT_W-1:0] rep_height;

  out_item_t expected_events[$];
  in_item_t beat_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int queued_beats = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int heights_seen = 0;
  int polls_seen = 0;
  int fault_count = 0;
  int cycle_count = 0;
  int last_hd = 1;
  int last_td = 2;
  int last_od = 3;
  logic last_dp = 1'b1;
  out_item_t want;

  function automatic logic [6:0] seg_shape(input int d);
    logic [6:0] s;
    case (d)
      0:       s = 7'h3F;
      1:       s = 7'h06;
      2:       s = 7'h5B;
      3:       s = 7'h4F;
      4:       s = 7'h66;
      5:       s = 7'h6D;
      6:       s = 7'h7D;
      7:       s = 7'h07;
      8:       s = 7'h7F;
      9:       s = 7'h6F;
      default: s = 7'h40;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] seg_value(input logic [7:0] b);
    logic [3:0] v;
    v = (b[6:0] == 7'h00) ? SEG_BLANK : SEG_BAD;
    for (int d = 0; d <= DIG_MINUS; d++) begin
      if (seg_shape(d) == b[6:0]) v = 4'(d);
    end
    return v;
  endfunction

  function automatic void push_event(input logic [EVENT_W-1:0] ev,
                                     input logic [HEIGHT_W-1:0] h);
    expected_events.push_back({ev, h});
  endfunction

  task automatic close_height_frame();
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] c;
    logic keep;
    logic [HEIGHT_W-1:0] h;
    keep = (frame_buf[2] == TYPE_HEIGHT) && (frame_buf[1] == HEIGHT_LEN);
    a = seg_value(frame_buf[3]);
    b = seg_value(frame_buf[4]);
    c = seg_value(frame_buf[5]);
    if (a == SEG_BLANK && b == SEG_BLANK && c == SEG_BLANK) keep = 1'b0;
    if (a == SEG_BLANK) a = 4'd0;
    if (a > SEG_MINUS || b > SEG_MINUS || c > SEG_MINUS) keep = 1'b0;
    if (a == 4'd0 && b == 4'd0 && c == 4'd0) keep = 1'b0;
    if (b == SEG_MINUS) keep = 1'b0;
    if (keep) begin
      h = HEIGHT_W'(a * 100 + b * 10 + c);
      if (!frame_buf[4][7]) h = HEIGHT_W'(h * 10);
      if (h != cur_height) begin
        last_change = now_ms;
        if (cur_height != '0 && mode == MODE_IDLE) mode = MODE_ACTIVE;
      end
      cur_height = h;
      if (cur_height != '0 && cur_height != rep_height) begin
        rep_height = cur_height;
        push_event(EV_HEIGHT, cur_height);
      end
    end
  endtask

  task automatic take_link_byte(input logic [7:0] b);
    int total;
    if (frame_fill == 0) begin
      if (b == SOF_A_BYTE || b == SOF_B_BYTE) begin
        frame_buf[0] = b;
        frame_fill = 1;
      end
    end else begin
      if (frame_fill < FRAME_MAX) begin
        frame_buf[frame_fill] = b;
        frame_fill++;
      end
      total = int'(frame_buf[1]) + 2;
      if (total > FRAME_MAX) begin
        frame_fill = 0;
        push_event(EV_OVERSIZE, '0);
      end else if (frame_fill >= total) begin
        if (frame_buf[total-1] == EOF_BYTE) begin
          close_height_frame();
        end else begin
          push_event(EV_BAD_END, '0);
        end
        frame_fill = 0;
      end
    end
  endtask

  task automatic advance_clock();
    now_ms = now_ms + 1;
    case (mode)
      MODE_BOOT: begin
        if (now_ms >= TIME_W'(boot_wait)) begin
          last_poll = now_ms;
          mode = MODE_IDLE;
          push_event(EV_DISPLAY, '0);
        end
      end
      MODE_ACTIVE: begin
        if (TIME_W'(now_ms - last_poll) >= TIME_W'(active_poll)) begin
          last_poll = now_ms;
          push_event(EV_WAKE, '0);
        end
        if (TIME_W'(now_ms - last_change) >= TIME_W'(act_timeout)) mode = MODE_IDLE;
      end
      default: begin
        if (TIME_W'(now_ms - last_poll) >= TIME_W'(idle_poll)) begin
          last_poll = now_ms;
          push_event(EV_WAKE, '0);
        end
      end
    endcase
  endtask

  task automatic decode_beat(input in_item_t b);
    if (b.kind == KIND_TICK) begin
      advance_clock();
    end else begin
      take_link_byte(b.rx_byte);
    end
  endtask

  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_beat(in_item);
        beats_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_item <= beat_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          log_fault($sformatf("unexpected result event %0d height %0d",
                              out_item.event_res, out_item.height_tenths));
        end else begin
          want = expected_events.pop_front();
          if (want.event_res == EV_HEIGHT) heights_seen++;
          if (want.event_res == EV_WAKE) polls_seen++;
          if (out_item.event_res !== want.event_res ||
              out_item.height_tenths !== want.height_tenths) begin
            log_fault($sformatf("got event %0d height %0d, expected event %0d height %0d",
                                out_item.event_res, out_item.height_tenths,
                                want.event_res, want.height_tenths));
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic push_beat(input logic kind, input logic [7:0] b);
    beat_q.push_back({kind, b});
    queued_beats++;
  endtask

  task automatic queue_ticks(input int n);
    for (int i = 0; i < n; i++) push_beat(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] digit_byte(input int d, input logic dp);
    logic [6:0] s;
    if (d <= DIG_MINUS) begin
      s = seg_shape(d);
    end else if (d == DIG_BLANK) begin
      s = 7'h00;
    end else begin
      s = 7'($urandom_range(1, 127));
      while (seg_value({1'b0, s}) != SEG_BAD) s = 7'($urandom_range(1, 127));
    end
    return {dp, s};
  endfunction

  function automatic int pick_digit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(0, 9);
    if (r < 92) return DIG_MINUS;
    if (r < 96) return DIG_BLANK;
    return DIG_ODD;
  endfunction

  function automatic logic [7:0] pick_start();
    return ($urandom_range(0, 1) == 0) ? SOF_A_BYTE : SOF_B_BYTE;
  endfunction

  task automatic queue_height_digits(input logic [7:0] start, input int hd, input int td,
                                     input int od, input logic tenths);
    push_beat(KIND_BYTE, start);
    push_beat(KIND_BYTE, HEIGHT_LEN);
    push_beat(KIND_BYTE, TYPE_HEIGHT);
    push_beat(KIND_BYTE, digit_byte(hd, 1'($urandom_range(0, 1))));
    push_beat(KIND_BYTE, digit_byte(td, tenths));
    push_beat(KIND_BYTE, digit_byte(od, 1'($urandom_range(0, 1))));
    push_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
    push_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
    push_beat(KIND_BYTE, EOF_BYTE);
  endtask

  task automatic queue_random_height();
    if ($urandom_range(0, 3) != 0) begin
      last_hd = pick_digit();
      last_td = pick_digit();
      last_od = pick_digit();
      last_dp = 1'($urandom_range(0, 1));
    end
    queue_height_digits(pick_start(), last_hd, last_td, last_od, last_dp);
  endtask

  // Frames of any length up to the buffer size; the last byte closes the
  // frame properly unless a bad end is asked for or the length is zero.
  task automatic queue_plain_frame(input logic bad_end);
    int len;
    logic [7:0] kind_byte;
    logic [7:0] tail;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, FRAME_MAX - 2) : $urandom_range(0, 8);
    kind_byte = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      kind_byte = TYPE_HEIGHT;
      if (len == int'(HEIGHT_LEN)) len = len + 1;
    end
    tail = EOF_BYTE;
    if (bad_end) begin
      tail = 8'($urandom_range(0, 255));
      if (tail == EOF_BYTE) tail = tail ^ 8'h01;
    end
    push_beat(KIND_BYTE, pick_start());
    push_beat(KIND_BYTE, 8'(len));
    for (int i = 2; i <= len + 1; i++) begin
      if (i == len + 1) push_beat(KIND_BYTE, tail);
      else if (i == 2) push_beat(KIND_BYTE, kind_byte);
      else push_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic queue_random_traffic(input int target);
    int first;
    int r;
    first = queued_beats;
    while (queued_beats - first < target) begin
      r = $urandom_range(0, 99);
      if (r < 42) begin
        queue_ticks($urandom_range(1, 5));
      end else if (r < 80) begin
        queue_random_height();
      end else if (r < 88) begin
        queue_plain_frame(1'b0);
      end else if (r < 91) begin
        queue_plain_frame(1'b1);
      end else if (r < 95) begin
        push_beat(KIND_BYTE, pick_start());
        push_beat(KIND_BYTE, 8'($urandom_range(FRAME_MAX - 1, 255)));
      end else begin
        for (int i = $urandom_range(1, 3); i > 0; i--) begin
          beat_q.push_back({KIND_BYTE, 8'($urandom_range(0, 255))});
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BOOT_WAIT:   boot_wait = val;
      REG_IDLE_POLL:   idle_poll = val;
      REG_ACTIVE_POLL: active_poll = val;
      default:         act_timeout = val;
    endcase
  endtask

  task automatic load_timing(input logic [CFG_DATA_W-1:0] boot, input logic [CFG_DATA_W-1:0] idle,
                             input logic [CFG_DATA_W-1:0] active,
                             input logic [CFG_DATA_W-1:0] timeout);
    write_reg(REG_BOOT_WAIT, boot);
    write_reg(REG_IDLE_POLL, idle);
    write_reg(REG_ACTIVE_POLL, active);
    write_reg(REG_ACT_TIMEOUT, timeout);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (beat_q.size() != 0 || in_valid || expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    boot_wait = BOOT_WAIT_RST;
    idle_poll = IDLE_POLL_RST;
    active_poll = ACTIVE_POLL_RST;
    act_timeout = ACT_TIMEOUT_RST;
    frame_fill = 0;
    mode = MODE_BOOT;
    now_ms = '0;
    last_poll = '0;
    last_change = '0;
    cur_height = '0;
    rep_height = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    load_timing(20'd2, 20'd6, 20'd2, 20'd5);
    send_idle_pct = 12;
    recv_idle_pct = 67;
    // The display command fires on the second tick; then the tallest and the
    // smallest readings, with a stray byte, an oversize and an empty frame.
    queue_ticks(2);
    push_beat(KIND_BYTE, 8'h55);
    queue_height_digits(SOF_A_BYTE, DIG_MINUS, 9, DIG_MINUS, 1'b0);
    push_beat(KIND_BYTE, SOF_A_BYTE);
    push_beat(KIND_BYTE, 8'(FRAME_MAX - 1));
    push_beat(KIND_BYTE, SOF_B_BYTE);
    push_beat(KIND_BYTE, 8'h00);
    queue_height_digits(SOF_B_BYTE, 0, 0, 1, 1'b1);
    queue_random_traffic(210);
    drain_results();

    load_timing(20'hFFFFF, 20'd1, 20'd0, 20'd1);
    send_idle_pct = 67;
    recv_idle_pct = 12;
    queue_random_traffic(230);
    drain_results();

    load_timing(20'd0, 20'hFFFFF, 20'd4, 20'hFFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_traffic(230);
    drain_results();
    repeat (8) @(posedge clk);

    if (expected_events.size() != 0) begin
      log_fault($sformatf("%0d expected results never arrived", expected_events.size()));
    end
    $display("Sent %0d beats over three timing setups; checked %0d results.",
             beats_sent, results_seen);
    $display("Results included %0d height reports and %0d wake polls; %0d mismatches.",
             heights_seen, polls_seen, fault_count);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ddfd_pkg.sv
rtl/ddfd_parser.sv
rtl/ddfd_poll.sv
rtl/desk_display_frame_decoder_unit.sv
tb/sv/tb.sv
